### rtl/assert_macros.svh
// Assertion helpers, clocked on clk_i and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SRL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/srl_pkg.sv
package srl_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned STEP_W   = 19;
  localparam int unsigned VOL_W    = 7;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned SKIP_W   = 4;
  localparam int unsigned RUN_W    = 5;   // run of up to 32 outputs
  localparam int unsigned MUL_W    = 24;
  localparam int unsigned PROD_W   = 2 * MUL_W;
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME     = 1'b1;

  localparam logic [STEP_W-1:0] PHASE_STEP_RST = 19'd65536;
  localparam logic [VOL_W-1:0]  VOLUME_RST     = 7'd127;

  // ceil(2^29 / 127): exact floor division for numerators below 2^22
  localparam logic [22:0] RECIP_127   = 23'd4227331;
  localparam int unsigned RECIP_SHIFT = 29;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       track_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_op_t;

endpackage

### rtl/srl_mul.sv
// Shared signed multiplier, product registered.
module srl_mul (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  srl_pkg::mul_op_t                    op_i,
  output logic signed [srl_pkg::PROD_W-1:0]   prod_o
);

  logic signed [srl_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= op_i.a * op_i.b;
    end
  end

  assign prod_o = prod_q;

endmodule

### rtl/stereo_linear_resampler.sv
// An input frame that yields no result (first frame, skipped pair) only updates the stored state.
// A frame that starts a run is accepted, then each output frame takes both channels through
// the interpolate, gain and divide passes of the shared multiplier and a collect state.
// No new input frame is accepted until the run ends; output back-pressure holds the sequencer in ST_DONE.
// Reset (rst_ni low, asynchronous): phase_step 65536, volume 127, previous frame,
// phase and skip count cleared, no item held. No clearing pass is needed.
`include "assert_macros.svh"

module stereo_linear_resampler (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input frames
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  srl_pkg::in_item_t                    in_item_i,
  // output frames
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output srl_pkg::out_item_t                   out_item_o,
  // register writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [srl_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [srl_pkg::STEP_W-1:0]           cfg_data_i
);

  // Sequencer: per channel, interpolate ((b-a)*f), apply gain (s*vol),
  // divide by 127 (|x| * reciprocal), then collect the result.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INTERP,
    ST_GAIN,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [srl_pkg::STEP_W-1:0] step_q, step_d;
  logic [srl_pkg::VOL_W-1:0]  vol_q, vol_d;

  // resampler state
  logic signed [srl_pkg::SAMPLE_W-1:0] prev_left_q, prev_left_d;
  logic signed [srl_pkg::SAMPLE_W-1:0] prev_right_q, prev_right_d;
  logic                                have_prev_q, have_prev_d;
  logic [srl_pkg::FRAC_W-1:0]          phase_q, phase_d;
  logic [srl_pkg::SKIP_W-1:0]          skip_q, skip_d;
  logic [srl_pkg::RUN_W-1:0]           run_cnt_q, run_cnt_d;
  logic                                ch_q, ch_d;        // 0 left, 1 right
  logic                                out_valid_q, out_valid_d;

  // payload registers, no reset
  srl_pkg::in_item_t                   cur_q, cur_d;
  logic signed [srl_pkg::SAMPLE_W-1:0] lres_q, lres_d;
  logic                                neg_q, neg_d;
  srl_pkg::out_item_t                  out_item_q, out_item_d;

  // shared multiplier
  logic                                mul_en;
  srl_pkg::mul_op_t                    mul_op;
  logic signed [srl_pkg::PROD_W-1:0]   prod;

  srl_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .op_i   (mul_op),
    .prod_o (prod)
  );

  // datapath helpers
  logic signed [srl_pkg::SAMPLE_W-1:0] a_sel, b_sel;
  logic signed [srl_pkg::SAMPLE_W:0]   diff;
  logic        [srl_pkg::SAMPLE_W+1:0] interp_sum;
  logic signed [srl_pkg::SAMPLE_W-1:0] interp_s;
  logic        [srl_pkg::MUL_W-1:0]    gain_x, gain_mag;
  logic        [srl_pkg::SAMPLE_W-1:0] quot, chan_res;
  logic        [srl_pkg::FRAC_W+3:0]   phase_sum;
  logic        [srl_pkg::SKIP_W-1:0]   carry;
  logic                                run_last;
  logic                                load_out;

  logic in_acc;
  logic start;
  logic eff_have;
  logic [srl_pkg::SKIP_W-1:0] eff_skip;
  logic [srl_pkg::FRAC_W-1:0] eff_phase;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign a_sel = ch_q ? prev_right_q : prev_left_q;
  assign b_sel = ch_q ? cur_q.right_in : cur_q.left_in;
  assign diff  = {b_sel[15], b_sel} - {a_sel[15], a_sel};

  // a + floor((b-a)*f / 2^16); stays within the sample range
  assign interp_sum = {{2{a_sel[15]}}, a_sel} + {prod[32], prod[32:16]};
  assign interp_s   = interp_sum[15:0];

  // s*vol fits in 23 bits signed
  assign gain_x   = prod[23:0];
  assign gain_mag = gain_x[23] ? (~gain_x + 24'd1) : gain_x;

  // truncation toward zero: divide the magnitude, then restore the sign
  assign quot     = prod[srl_pkg::RECIP_SHIFT+15:srl_pkg::RECIP_SHIFT];
  assign chan_res = neg_q ? (~quot + 16'd1) : quot;

  assign phase_sum = {4'b0, phase_q} + {1'b0, step_q};
  assign carry     = phase_sum[19:16];
  assign run_last  = (carry != '0) || (&run_cnt_q);

  // track_start clears state ahead of this frame
  assign start     = in_item_i.track_start;
  assign eff_have  = have_prev_q && !start;
  assign eff_skip  = start ? '0 : skip_q;
  assign eff_phase = start ? '0 : phase_q;

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    vol_d        = vol_q;
    prev_left_d  = prev_left_q;
    prev_right_d = prev_right_q;
    have_prev_d  = have_prev_q;
    phase_d      = phase_q;
    skip_d       = skip_q;
    run_cnt_d    = run_cnt_q;
    ch_d         = ch_q;
    out_valid_d  = out_valid_q;
    cur_d        = cur_q;
    lres_d       = lres_q;
    neg_d        = neg_q;
    out_item_d   = out_item_q;
    mul_en       = 1'b0;
    mul_op       = '0;
    load_out     = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      case (cfg_index_i)
        srl_pkg::CFG_PHASE_STEP: step_d = cfg_data_i;
        srl_pkg::CFG_VOLUME:     vol_d  = cfg_data_i[srl_pkg::VOL_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!eff_have) begin
            // first frame: store only
            have_prev_d  = 1'b1;
            prev_left_d  = in_item_i.left_in;
            prev_right_d = in_item_i.right_in;
            phase_d      = eff_phase;
            skip_d       = '0;
          end else if (eff_skip != '0) begin
            skip_d       = eff_skip - 4'd1;
            prev_left_d  = in_item_i.left_in;
            prev_right_d = in_item_i.right_in;
            phase_d      = eff_phase;
          end else begin
            cur_d        = in_item_i;
            prev_left_d  = start ? '0 : prev_left_q;
            prev_right_d = start ? '0 : prev_right_q;
            phase_d      = eff_phase;
            skip_d       = '0;
            run_cnt_d    = '0;
            ch_d         = 1'b0;
            state_d      = ST_INTERP;
          end
        end
      end
      ST_INTERP: begin
        mul_en   = 1'b1;
        mul_op.a = {{7{diff[16]}}, diff};
        mul_op.b = {8'b0, phase_q};
        state_d  = ST_GAIN;
      end
      ST_GAIN: begin
        mul_en   = 1'b1;
        mul_op.a = {{8{interp_s[15]}}, interp_s};
        mul_op.b = {17'b0, vol_q};
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        mul_en   = 1'b1;
        mul_op.a = gain_mag;
        mul_op.b = {1'b0, srl_pkg::RECIP_127};
        neg_d    = gain_x[23];
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (!ch_q) begin
          lres_d  = chan_res;
          ch_d    = 1'b1;
          state_d = ST_INTERP;
        end else if (!out_valid_q || out_ready_i) begin
          // output slot free: emit and step the phase
          load_out               = 1'b1;
          out_valid_d            = 1'b1;
          out_item_d.left_out    = lres_q;
          out_item_d.right_out   = chan_res;
          out_item_d.last_of_run = run_last;
          phase_d                = phase_sum[15:0];
          run_cnt_d              = run_cnt_q + 5'd1;
          ch_d                   = 1'b0;
          if (run_last) begin
            skip_d       = (carry != '0) ? (carry - 4'd1) : '0;
            prev_left_d  = cur_q.left_in;
            prev_right_d = cur_q.right_in;
            state_d      = ST_IDLE;
          end else begin
            state_d = ST_INTERP;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= srl_pkg::PHASE_STEP_RST;
      vol_q        <= srl_pkg::VOLUME_RST;
      prev_left_q  <= '0;
      prev_right_q <= '0;
      have_prev_q  <= 1'b0;
      phase_q      <= '0;
      skip_q       <= '0;
      run_cnt_q    <= '0;
      ch_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      vol_q        <= vol_d;
      prev_left_q  <= prev_left_d;
      prev_right_q <= prev_right_d;
      have_prev_q  <= have_prev_d;
      phase_q      <= phase_d;
      skip_q       <= skip_d;
      run_cnt_q    <= run_cnt_d;
      ch_q         <= ch_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    lres_q     <= lres_d;
    neg_q      <= neg_d;
    out_item_q <= out_item_d;
  end

  // a run only starts from a stored frame with nothing left to skip
  `SRL_ASSERT_IMPL(a_run_has_prev, state_q != ST_IDLE, have_prev_q && skip_q == '0, "run start")
  // the last frame of a run returns the sequencer to idle
  `SRL_ASSERT_IMPL(a_last_ends_run, load_out && run_last, state_d == ST_IDLE, "run did not end")
  // any other emitted frame continues the run
  `SRL_ASSERT_IMPL(a_run_continues, load_out && !run_last, state_d == ST_INTERP, "run ended early")
  // an emitted frame is never overwritten before it is taken
  `SRL_ASSERT_IMPL(a_no_overwrite, load_out, !out_valid_q || out_ready_i, "output overwritten")

endmodule
